@@ design/wes_pkg.sv @@
// ----------------------------------------------------------------------------
// wes_pkg
// Shared constants, register codes and the CORDIC arctangent table for the
// wave elevation synthesizer.
// ----------------------------------------------------------------------------
package wes_pkg;

    localparam int MAX_COMPONENTS_DEF = 64;
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int CORDIC_TAB_LEN     = 24;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd2547003;
    localparam logic [22:0] ONE_Q22       = 23'd4194304;
    localparam logic [19:0] G_Q16         = 20'd642689;
    localparam logic [19:0] G_HALF        = 20'd321344;
    // floor(2^37 / G_Q16)
    localparam logic [17:0] G_RECIP       = 18'd213849;
    localparam logic [18:0] INV2PI_Q21    = 19'd333772;
    // 1/(2*pi) in Q36 is 2 * 2^32 + INV2PI_Q36_LO
    localparam logic [31:0] INV2PI_Q36_LO = 32'd2347109817;

    typedef enum logic {
        REG_RAMP_TIME       = 1'b0,
        REG_COMPONENT_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        COR_RAMP,
        COR_HEAD,
        COR_PHASE
    } cor_sel_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ design/wes_in_if.sv @@
// ----------------------------------------------------------------------------
// wes_in_if
// Input item channel: load or evaluate request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wes_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [5:0]         slot;
    logic [15:0]        amplitude;
    logic [15:0]        frequency;
    logic [15:0]        heading;
    logic [15:0]        phase_offset;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] time_now;

    modport source
    (
        output valid, kind, slot, amplitude, frequency, heading, phase_offset,
        output pos_x, pos_y, time_now,
        input  ready
    );
    modport sink
    (
        input  valid, kind, slot, amplitude, frequency, heading, phase_offset,
        input  pos_x, pos_y, time_now,
        output ready
    );
endinterface

@@ design/wes_out_if.sv @@
// ----------------------------------------------------------------------------
// wes_out_if
// Result item channel: elevation or load acknowledge with valid/ready.
// ----------------------------------------------------------------------------
interface wes_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] elevation;
    logic               is_elevation;

    modport source
    (
        output valid, elevation, is_elevation,
        input  ready
    );
    modport sink
    (
        input  valid, elevation, is_elevation,
        output ready
    );
endinterface

@@ design/wave_elevation_synthesizer_core.sv @@
// ----------------------------------------------------------------------------
// wave_elevation_synthesizer_core
// Sums linear deep-water wave components at a point and time, using one
// shared CORDIC, one shared multiplier and one restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   item_in carries one item per valid/ready handshake. kind 0 loads a
//   component into slot (amplitude, frequency, heading, phase offset) and
//   computes its wavenumber. kind 1 evaluates the elevation at pos_x/pos_y
//   and time_now over the first component_count components (at most MAX_COMPONENTS).
//   result_out returns exactly one item per input item: a load acknowledge
//   (elevation 0, is_elevation 0) or the saturated elevation sum.
//   A load runs the frequency square, a reciprocal multiply by 1/g and
//   up to two correction subtracts.
//   An evaluation runs a restoring divide and a CORDIC run for the ramp
//   when time_now lies inside the ramp, then for each component two
//   16-step CORDIC runs and eleven passes through the shared multiplier.
//   One item is in work at a time; item_in.ready is high only when idle.
//   A result holds on result_out until taken; the next item is accepted
//   after that. Reset clears the sequencer and both registers; the
//   component tables hold garbage until loaded. ramp_time and
//   component_count are written over APB at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module wave_elevation_synthesizer_core
#(
    parameter int MAX_COMPONENTS = wes_pkg::MAX_COMPONENTS_DEF,
    parameter int CORDIC_STEPS   = wes_pkg::CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    wes_in_if.sink      item_in,
    wes_out_if.source   result_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wes_pkg::*;

    localparam int AW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int IW    = $clog2(MAX_COMPONENTS + 1);
    localparam int COR_N = (CORDIC_STEPS > CORDIC_TAB_LEN) ? CORDIC_TAB_LEN : CORDIC_STEPS;

    typedef enum logic [5:0] {
        S_IDLE, S_L_SQ, S_L_DIV0, S_L_Q1, S_L_Q2, S_L_Q3, S_L_FIX, S_DIV, S_L_WR,
        S_E_RAMP, S_R_FIN, S_E_COMP,
        S_E_RD, S_E_H0, S_COR, S_E_D1, S_E_D2, S_E_D3, S_E_K1, S_E_K2, S_E_K3,
        S_E_S1, S_E_S2, S_E_S3, S_E_W1, S_E_W2, S_E_T1, S_E_T2, S_E_T3,
        S_E_A1, S_E_A2, S_E_A3, S_E_SAT, S_OUT
    } state_t;

    // component tables
    logic [31:0] af_mem [MAX_COMPONENTS];
    logic [31:0] hp_mem [MAX_COMPONENTS];
    logic [17:0] k_mem  [MAX_COMPONENTS];
    logic [31:0] af_q_reg, hp_q_reg;
    logic [17:0] k_q_reg;
    logic        mem_we;

    state_t             state_reg, state_next;
    logic [15:0]        ramp_time_reg, ramp_time_next;
    logic [6:0]         ccount_reg, ccount_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] elev_reg, elev_next;
    logic               is_elev_reg, is_elev_next;
    logic [5:0]         slot_reg, slot_next;
    logic [15:0]        amp_reg, amp_next;
    logic [15:0]        freq_reg, freq_next;
    logic [15:0]        head_reg, head_next;
    logic [15:0]        eps_reg, eps_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;
    logic signed [31:0] t_reg, t_next;
    logic [22:0]        ramp_reg, ramp_next;
    logic [IW-1:0]      n_reg, n_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic [1:0]         quad_reg, quad_next;
    logic [4:0]         step_reg, step_next;
    cor_sel_t           cor_sel_reg, cor_sel_next;
    logic [47:0]        num_reg, num_next;
    logic [19:0]        rem_reg, rem_next;
    logic [19:0]        den_reg, den_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic [63:0]        p_reg, p_next;
    logic [63:0]        a_reg, a_next;
    logic [63:0]        b_reg, b_next;
    logic signed [31:0] sh_reg, sh_next;
    logic [31:0]        sp_reg, sp_next;
    logic signed [31:0] cp_reg, cp_next;
    logic signed [47:0] sum_reg, sum_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic signed [31:0] cos_w, sin_w;
    logic               cor_start;
    logic [31:0]        cor_ang;
    logic [31:0]        cor_shift;
    logic signed [31:0] dx, dy;
    logic [31:0]        at;
    logic [20:0]        trial;
    logic               qbit;
    logic [63:0]        wide_sum;
    logic signed [32:0] rdiff;
    logic [10:0]        ccount_ext;
    logic               cfg_wr;
    logic               slot_ok;

    assign mul_full   = mul_a * mul_b;
    assign cfg_wr     = psel & penable & pwrite;
    assign pready     = 1'b1;
    assign ccount_ext = {4'b0, ccount_reg};
    assign slot_ok    = ({5'b0, slot_reg} < 11'(MAX_COMPONENTS));

    assign item_in.ready           = (state_reg == S_IDLE);
    assign result_out.valid        = out_valid_reg;
    assign result_out.elevation    = elev_reg;
    assign result_out.is_elevation = is_elev_reg;

    always_comb
    begin
        case (cfg_reg_t'(paddr[2]))
            REG_RAMP_TIME:       prdata = {16'b0, ramp_time_reg};
            REG_COMPONENT_COUNT: prdata = {25'b0, ccount_reg};
            default:             prdata = '0;
        endcase
    end

    // quadrant fold of the CORDIC output
    always_comb
    begin
        case (quad_reg)
            2'd0:    begin cos_w = x_reg;  sin_w = y_reg;  end
            2'd1:    begin cos_w = -y_reg; sin_w = x_reg;  end
            2'd2:    begin cos_w = -x_reg; sin_w = -y_reg; end
            default: begin cos_w = y_reg;  sin_w = -x_reg; end
        endcase
    end

    assign dx    = y_reg >>> step_reg;
    assign dy    = x_reg >>> step_reg;
    assign at    = atan_turn(step_reg);
    assign trial = {rem_reg, num_reg[47]};
    assign qbit  = (trial >= {1'b0, den_reg});
    assign rdiff = $signed({10'b0, ONE_Q22}) - $signed({cos_w[31], cos_w});

    always_comb
    begin
        state_next     = state_reg;
        ramp_time_next = ramp_time_reg;
        ccount_next    = ccount_reg;
        out_valid_next = out_valid_reg;
        elev_next      = elev_reg;
        is_elev_next   = is_elev_reg;
        slot_next      = slot_reg;
        amp_next       = amp_reg;
        freq_next      = freq_reg;
        head_next      = head_reg;
        eps_next       = eps_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        t_next         = t_reg;
        ramp_next      = ramp_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        quad_next      = quad_reg;
        step_next      = step_reg;
        cor_sel_next   = cor_sel_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        dcnt_next      = dcnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        sh_next        = sh_reg;
        sp_next        = sp_reg;
        cp_next        = cp_reg;
        sum_next       = sum_reg;
        mul_a          = '0;
        mul_b          = '0;
        cor_start      = 1'b0;
        cor_ang        = '0;
        wide_sum       = '0;
        mem_we         = 1'b0;

        if (cfg_wr)
        begin
            case (cfg_reg_t'(paddr[2]))
                REG_RAMP_TIME:       ramp_time_next = pwdata[15:0];
                REG_COMPONENT_COUNT: ccount_next    = pwdata[6:0];
                default:             ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_in.valid)
                begin
                    slot_next  = item_in.slot;
                    amp_next   = item_in.amplitude;
                    freq_next  = item_in.frequency;
                    head_next  = item_in.heading;
                    eps_next   = item_in.phase_offset;
                    px_next    = item_in.pos_x;
                    py_next    = item_in.pos_y;
                    t_next     = item_in.time_now;
                    state_next = item_in.kind ? S_E_RAMP : S_L_SQ;
                end
            end
            S_L_SQ:
            begin
                mul_a      = {17'b0, freq_reg};
                mul_b      = {17'b0, freq_reg};
                state_next = S_L_DIV0;
            end
            S_L_DIV0:
            begin
                // rounded freq^2 * 32 / g
                num_next   = 48'({p_reg[31:0], 5'b0}) + 48'(G_HALF);
                state_next = S_L_Q1;
            end
            S_L_Q1:
            begin
                // quotient estimate from the truncated reciprocal, low by at most two
                mul_a      = {1'b0, num_reg[36:5]};
                mul_b      = {15'b0, G_RECIP};
                state_next = S_L_Q2;
            end
            S_L_Q2:
            begin
                a_next     = {46'b0, p_reg[49:32]};
                mul_a      = {15'b0, p_reg[49:32]};
                mul_b      = {13'b0, G_Q16};
                state_next = S_L_Q3;
            end
            S_L_Q3:
            begin
                b_next     = {16'b0, num_reg} - p_reg;
                state_next = S_L_FIX;
            end
            S_L_FIX:
            begin
                if (b_reg >= {44'b0, G_Q16})
                begin
                    b_next = b_reg - {44'b0, G_Q16};
                    a_next = a_reg + 64'd1;
                end
                else
                begin
                    state_next = S_L_WR;
                end
            end
            S_DIV:
            begin
                rem_next  = qbit ? 20'(trial - {1'b0, den_reg}) : trial[19:0];
                num_next  = {num_reg[46:0], qbit};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd47)
                begin
                    cor_start    = 1'b1;
                    cor_ang      = num_next[31:0];
                    cor_sel_next = COR_RAMP;
                    state_next   = S_COR;
                end
            end
            S_L_WR:
            begin
                mem_we         = slot_ok;
                elev_next      = '0;
                is_elev_next   = 1'b0;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_E_RAMP:
            begin
                if (ccount_ext > 11'(MAX_COMPONENTS))
                    n_next = IW'(MAX_COMPONENTS);
                else
                    n_next = IW'(ccount_reg);
                idx_next = '0;
                sum_next = '0;
                if (ramp_time_reg == 16'd0)
                begin
                    ramp_next  = ONE_Q22;
                    state_next = S_E_COMP;
                end
                else if (t_reg <= 32'sd0)
                begin
                    ramp_next  = '0;
                    state_next = S_E_COMP;
                end
                else if (t_reg >= $signed({8'b0, ramp_time_reg, 8'b0}))
                begin
                    ramp_next  = ONE_Q22;
                    state_next = S_E_COMP;
                end
                else
                begin
                    // t stays below 2^24 here
                    num_next   = {1'b0, t_reg[23:0], 23'b0};
                    den_next   = {4'b0, ramp_time_reg};
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_R_FIN:
            begin
                if (rdiff < 33'sd0)
                    ramp_next = '0;
                else if (rdiff[32:1] > {9'b0, ONE_Q22})
                    ramp_next = ONE_Q22;
                else
                    ramp_next = rdiff[23:1];
                state_next = S_E_COMP;
            end
            S_E_COMP:
            begin
                state_next = (idx_reg == n_reg) ? S_E_SAT : S_E_RD;
            end
            S_E_RD:
            begin
                state_next = S_E_H0;
            end
            S_E_H0:
            begin
                cor_start    = 1'b1;
                cor_ang      = {hp_q_reg[31:16], 16'b0};
                cor_sel_next = COR_HEAD;
                state_next   = S_COR;
            end
            S_COR:
            begin
                if (z_reg >= 32'sd0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - $signed(at);
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + $signed(at);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(COR_N - 1))
                begin
                    case (cor_sel_reg)
                        COR_RAMP:  state_next = S_R_FIN;
                        COR_HEAD:  state_next = S_E_D1;
                        COR_PHASE: state_next = S_E_A1;
                        default:   state_next = S_E_A1;
                    endcase
                end
            end
            S_E_D1:
            begin
                mul_a      = {px_reg[31], px_reg};
                mul_b      = {cos_w[31], cos_w};
                sh_next    = sin_w;
                state_next = S_E_D2;
            end
            S_E_D2:
            begin
                a_next     = p_reg;
                mul_a      = {py_reg[31], py_reg};
                mul_b      = {sh_reg[31], sh_reg};
                state_next = S_E_D3;
            end
            S_E_D3:
            begin
                a_next     = a_reg + p_reg;
                state_next = S_E_K1;
            end
            S_E_K1:
            begin
                mul_a      = {1'b0, a_reg[31:0]};
                mul_b      = {15'b0, k_q_reg};
                state_next = S_E_K2;
            end
            S_E_K2:
            begin
                b_next     = p_reg;
                mul_a      = {1'b0, a_reg[63:32]};
                mul_b      = {15'b0, k_q_reg};
                state_next = S_E_K3;
            end
            S_E_K3:
            begin
                a_next     = b_reg + {p_reg[31:0], 32'b0};
                state_next = S_E_S1;
            end
            S_E_S1:
            begin
                mul_a      = {1'b0, a_reg[31:0]};
                mul_b      = {14'b0, INV2PI_Q21};
                state_next = S_E_S2;
            end
            S_E_S2:
            begin
                b_next     = p_reg;
                mul_a      = {1'b0, a_reg[63:32]};
                mul_b      = {14'b0, INV2PI_Q21};
                state_next = S_E_S3;
            end
            S_E_S3:
            begin
                wide_sum   = b_reg + {p_reg[31:0], 32'b0};
                sp_next    = wide_sum[63:32];
                state_next = S_E_W1;
            end
            S_E_W1:
            begin
                mul_a      = {17'b0, af_q_reg[15:0]};
                mul_b      = {t_reg[31], t_reg};
                state_next = S_E_W2;
            end
            S_E_W2:
            begin
                a_next     = p_reg;
                state_next = S_E_T1;
            end
            S_E_T1:
            begin
                mul_a      = {1'b0, a_reg[31:0]};
                mul_b      = {1'b0, INV2PI_Q36_LO};
                state_next = S_E_T2;
            end
            S_E_T2:
            begin
                // upper constant bits are 2: add the low word shifted by 33
                b_next     = p_reg + {a_reg[30:0], 33'b0};
                mul_a      = {1'b0, a_reg[63:32]};
                mul_b      = {1'b0, INV2PI_Q36_LO};
                state_next = S_E_T3;
            end
            S_E_T3:
            begin
                wide_sum     = b_reg + {p_reg[31:0], 32'b0};
                cor_start    = 1'b1;
                cor_ang      = sp_reg - wide_sum[63:32] + {hp_q_reg[15:0], 16'b0};
                cor_sel_next = COR_PHASE;
                state_next   = S_COR;
            end
            S_E_A1:
            begin
                cp_next    = cos_w;
                mul_a      = {17'b0, af_q_reg[31:16]};
                mul_b      = {10'b0, ramp_reg};
                state_next = S_E_A2;
            end
            S_E_A2:
            begin
                mul_a      = {16'b0, p_reg[38:22]};
                mul_b      = {cp_reg[31], cp_reg};
                state_next = S_E_A3;
            end
            S_E_A3:
            begin
                sum_next   = sum_reg + $signed({{2{p_reg[63]}}, p_reg[63:18]});
                idx_next   = idx_reg + 1'b1;
                state_next = S_E_COMP;
            end
            S_E_SAT:
            begin
                if (sum_reg > 48'sh0000_7FFF_FFFF)
                    elev_next = 32'sh7FFF_FFFF;
                else if (sum_reg < -48'sh0000_8000_0000)
                    elev_next = 32'sh8000_0000;
                else
                    elev_next = sum_reg[31:0];
                is_elev_next   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (result_out.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // load the CORDIC: fold the angle into one quadrant
        if (cor_start)
        begin
            cor_shift = cor_ang + 32'h20000000;
            quad_next = cor_shift[31:30];
            z_next    = $signed({2'b00, cor_shift[29:0]}) - 32'sh20000000;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            step_next = '0;
        end
        else
        begin
            cor_shift = '0;
        end
    end

    assign p_next = mul_full[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ramp_time_reg <= '0;
            ccount_reg    <= '0;
            out_valid_reg <= 1'b0;
            elev_reg      <= '0;
            is_elev_reg   <= 1'b0;
            slot_reg      <= '0;
            amp_reg       <= '0;
            freq_reg      <= '0;
            head_reg      <= '0;
            eps_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            t_reg         <= '0;
            ramp_reg      <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            quad_reg      <= '0;
            step_reg      <= '0;
            cor_sel_reg   <= COR_RAMP;
            num_reg       <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            dcnt_reg      <= '0;
            p_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            sh_reg        <= '0;
            sp_reg        <= '0;
            cp_reg        <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ramp_time_reg <= ramp_time_next;
            ccount_reg    <= ccount_next;
            out_valid_reg <= out_valid_next;
            elev_reg      <= elev_next;
            is_elev_reg   <= is_elev_next;
            slot_reg      <= slot_next;
            amp_reg       <= amp_next;
            freq_reg      <= freq_next;
            head_reg      <= head_next;
            eps_reg       <= eps_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            t_reg         <= t_next;
            ramp_reg      <= ramp_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            quad_reg      <= quad_next;
            step_reg      <= step_next;
            cor_sel_reg   <= cor_sel_next;
            num_reg       <= num_next;
            rem_reg       <= rem_next;
            den_reg       <= den_next;
            dcnt_reg      <= dcnt_next;
            p_reg         <= p_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            sh_reg        <= sh_next;
            sp_reg        <= sp_next;
            cp_reg        <= cp_next;
            sum_reg       <= sum_next;
        end
    end

    // component tables: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            af_mem[AW'(slot_reg)] <= {amp_reg, freq_reg};
            hp_mem[AW'(slot_reg)] <= {head_reg, eps_reg};
            k_mem[AW'(slot_reg)]  <= a_reg[17:0];
        end
        af_q_reg <= af_mem[idx_reg[AW-1:0]];
        hp_q_reg <= hp_mem[idx_reg[AW-1:0]];
        k_q_reg  <= k_mem[idx_reg[AW-1:0]];
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        item_in.ready |-> !result_out.valid)
        else $error("input ready while a result is pending");

    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.is_elevation) |-> (result_out.elevation == 32'sd0))
        else $error("load acknowledge with nonzero elevation");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= n_reg)
        else $error("component index ran past count");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dcnt_reg < 6'd48))
        else $error("divider step count out of range");

    a_cor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COR) |-> (step_reg < 5'(COR_N)))
        else $error("CORDIC step count out of range");

endmodule
